// ===== design/las_pkg.sv =====
// ----------------------------------------------------------------------------
// las_pkg
// Shared types and constants of the recency-ordered address set.
// ----------------------------------------------------------------------------
package las_pkg;

	// default number of slots
	localparam int LAS_ENTRIES = 64;

	// fixed field widths
	localparam int ADDR_W = 48;
	localparam int CAP_W  = 7;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// request kinds
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FIX,
		ST_FINISH
	} las_state_t;

endpackage

// ===== design/las_ram.sv =====
// ----------------------------------------------------------------------------
// las_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module las_ram
	import las_pkg::*;
#(
	parameter int WIDTH = ADDR_W,
	parameter int DEPTH = LAS_ENTRIES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lru_address_set_core.sv =====
// ----------------------------------------------------------------------------
// lru_address_set_core
// Recency-ordered set of distinct 48-bit MAC addresses with LRU eviction.
// ----------------------------------------------------------------------------
// Each request either adds/refreshes an address (kind 0) or drops the least
// recent entry (kind 1), and answers with the number of addresses held.
// Addresses and recency ranks live in one RAM with a registered read; valid
// bits sit in flip-flops and clear at reset, so the set starts empty at once.
// Requests are handled one at a time by a sequencer that sweeps the RAM: a
// search pass finds the hit, the oldest slot and the first free slot, then
// an add runs a read-modify-write pass that renumbers the ranks; a remove
// or a dropped add skips that second pass. The next request is taken once
// the result has been placed in the output register.
// ----------------------------------------------------------------------------
module lru_address_set_core
	import las_pkg::*;
#(
	parameter int ENTRIES = LAS_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [ADDR_W-1:0]                address,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [$clog2(ENTRIES+1)-1:0]     count,
	// capacity register
	input  logic                             cfg_we,
	input  logic [CAP_W-1:0]                 cfg_wdata
);

	localparam int IW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int RW   = ADDR_W + IW;
	localparam logic [IW-1:0]   LAST     = IW'(ENTRIES - 1);
	localparam logic [CAPW-1:0] ENT_WIDE = CAPW'(ENTRIES);

	las_state_t state_q, state_d;

	logic [CAP_W-1:0]   cap_q;
	logic [CW-1:0]      cnt_q;
	logic [ENTRIES-1:0] vld_q;
	logic               out_valid_q;
	logic [CW-1:0]      count_q;

	logic               kind_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               pass_issue_q;
	logic [IW-1:0]      ptr_q;
	logic               rd_v_s1;
	logic [IW-1:0]      idx_s1;

	logic               found_q;
	logic [IW-1:0]      fidx_q;
	logic [IW-1:0]      frank_q;
	logic [IW-1:0]      oidx_q;
	logic               free_found_q;
	logic [IW-1:0]      free_idx_q;
	logic [IW-1:0]      ins_idx_q;
	logic [IW-1:0]      evict_idx_q;

	logic [RW-1:0]      ram_rdata;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [RW-1:0]      ram_wdata;

	logic [ADDR_W-1:0]  rd_addr;
	logic [IW-1:0]      rd_rank;
	logic               rd_vld;
	logic [IW-1:0]      new_rank;
	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cap_eff;
	logic [CAPW-1:0]    cap_wide;
	logic               pass_end;
	logic               out_free;
	logic               go_update;

	// address and rank store
	las_ram #(
		.WIDTH(RW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// read data fields and derived values
	always_comb begin
		rd_addr  = ram_rdata[RW-1:IW];
		rd_rank  = ram_rdata[IW-1:0];
		rd_vld   = vld_q[idx_s1];
		cnt_m1   = cnt_q - 1'b1;
		cap_wide = CAPW'(cap_q);
		cap_eff  = (cap_wide > ENT_WIDE) ? CW'(ENTRIES) : cap_wide[CW-1:0];
		pass_end = rd_v_s1 && (idx_s1 == LAST);
		out_free = !out_valid_q || !out_stall;
		go_update = (kind_q == KIND_ADD) && (found_q || (cnt_q != '0) || (cnt_q < cap_eff));
	end

	// rank after the move to front, or after an insert at the front
	always_comb begin
		if (!found_q) begin
			new_rank = rd_rank + 1'b1;
		end else if (idx_s1 == fidx_q) begin
			new_rank = '0;
		end else if (rd_rank < frank_q) begin
			new_rank = rd_rank + 1'b1;
		end else begin
			new_rank = rd_rank;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (pass_end) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = go_update ? ST_UPDATE : ST_FINISH;
			end
			ST_UPDATE: begin
				if (pass_end) state_d = ST_FIX;
			end
			ST_FIX: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// handshake and RAM write port
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {rd_addr, new_rank};
		case (state_q)
			ST_UPDATE: begin
				ram_we = rd_v_s1 && rd_vld;
			end
			ST_FIX: begin
				ram_we    = !found_q;
				ram_waddr = ins_idx_q;
				ram_wdata = {addr_q, {IW{1'b0}}};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_RESET;
			cnt_q        <= '0;
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
			pass_issue_q <= 1'b0;
			rd_v_s1      <= 1'b0;
		end else begin
			state_q <= state_d;

			// capacity register
			if (cfg_we) cap_q <= cfg_wdata;

			// result taken downstream
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) out_valid_q <= 1'b0;

			// RAM sweep, one read per cycle
			rd_v_s1 <= pass_issue_q;
			if (pass_issue_q) begin
				idx_s1 <= ptr_q;
				if (ptr_q == LAST) begin
					pass_issue_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q       <= kind;
						addr_q       <= address;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						ptr_q        <= '0;
						pass_issue_q <= 1'b1;
					end
				end
				// search: hit, oldest slot, first free slot
				ST_SCAN: begin
					if (rd_v_s1) begin
						if (rd_vld && !found_q && (rd_addr == addr_q)) begin
							found_q <= 1'b1;
							fidx_q  <= idx_s1;
							frank_q <= rd_rank;
						end
						if (rd_vld && (CW'(rd_rank) == cnt_m1)) oidx_q <= idx_s1;
						if (!rd_vld && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
					end
				end
				// drop oldest where needed and pick the insert slot
				ST_DECIDE: begin
					if (kind_q == KIND_REMOVE) begin
						if (cnt_q != '0) begin
							vld_q[oidx_q] <= 1'b0;
							cnt_q         <= cnt_m1;
						end
					end else if (!found_q && go_update) begin
						if (cnt_q >= cap_eff) begin
							vld_q[oidx_q] <= 1'b0;
							cnt_q         <= cnt_m1;
							ins_idx_q     <= (free_found_q && (free_idx_q < oidx_q)) ?
								free_idx_q : oidx_q;
						end else begin
							ins_idx_q <= free_idx_q;
						end
					end
					if (go_update) begin
						ptr_q        <= '0;
						pass_issue_q <= 1'b1;
					end
				end
				// rank renumbering, track the oldest after a refresh
				ST_UPDATE: begin
					if (rd_v_s1 && rd_vld && found_q && (CW'(new_rank) == cnt_m1)) begin
						evict_idx_q <= idx_s1;
					end
				end
				// insert the new entry or trim after a refresh
				ST_FIX: begin
					if (found_q) begin
						if (cnt_q > cap_eff) begin
							vld_q[evict_idx_q] <= 1'b0;
							cnt_q              <= cnt_m1;
						end
					end else begin
						vld_q[ins_idx_q] <= 1'b1;
						cnt_q            <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= cnt_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result outputs
	assign out_valid = out_valid_q;
	assign count     = count_q;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recency-ordered MAC address set.
// ----------------------------------------------------------------------------
// Requests are queued by the main sequence and fed to the core by a clocked
// driver with random gaps. A clocked monitor applies random stalls and
// compares each returned count against a local LRU model that is updated
// when the driver sees a request accepted. Capacity is rewritten between
// phases while the core is idle. One long receiver hold-off makes the core
// back up and stall its request channel.
// ----------------------------------------------------------------------------
module tb_top;
	import las_pkg::*;

	localparam int ENTRIES     = LAS_ENTRIES;
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int RANK_W      = $clog2(ENTRIES);
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 600;
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] mac;
	} lru_req_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// core ports; the inputs are all known from time zero
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              kind      = KIND_ADD;
	logic [ADDR_W-1:0] address   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CNT_W-1:0]  count;
	logic              cfg_we    = 1'b0;
	logic [CAP_W-1:0]  cfg_wdata = '0;

	// request and expectation bookkeeping
	lru_req_t         pending_reqs [$];
	logic [CNT_W-1:0] count_q [$];
	int               open_reqs    = 0;
	int               errors       = 0;
	int               quiet_cycles = 0;
	bit               calm         = 1'b0;

	// local copy of the address set
	logic [ADDR_W-1:0] slot_addr [ENTRIES];
	logic [RANK_W-1:0] slot_rank [ENTRIES];
	logic              slot_live [ENTRIES];
	logic [CNT_W-1:0]  live_count;
	logic [CAP_W-1:0]  cap_reg;

	lru_address_set_core #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.address  (address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count    (count),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// mismatch reporting
	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// drop the least recent entry of the local set
	function automatic void drop_oldest();
		if (live_count == 0)
			return;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_live[i] && slot_rank[i] == live_count - 1) begin
				slot_live[i] = 1'b0;
				slot_rank[i] = '0;
				live_count--;
				return;
			end
		end
	endfunction

	// apply one request to the local set and return the count held after it
	function automatic logic [CNT_W-1:0] predict_count(input logic op,
			input logic [ADDR_W-1:0] mac);
		int hit;
		int cap_eff;
		bit placed;
		logic [RANK_W-1:0] r;
		hit = -1;
		placed = 1'b0;
		cap_eff = (cap_reg < ENTRIES) ? cap_reg : ENTRIES;
		if (op == KIND_REMOVE) begin
			drop_oldest();
		end else begin
			for (int i = 0; i < ENTRIES; i++)
				if (hit < 0 && slot_live[i] && slot_addr[i] == mac)
					hit = i;
			if (hit >= 0) begin
				// refresh: move to front, then trim if over capacity
				r = slot_rank[hit];
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i] && slot_rank[i] < r)
						slot_rank[i]++;
				slot_rank[hit] = '0;
				if (live_count > cap_eff)
					drop_oldest();
			end else if (!(live_count + 1 > cap_eff && live_count == 0)) begin
				// insert as most recent, evicting one entry if full
				if (live_count + 1 > cap_eff)
					drop_oldest();
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i])
						slot_rank[i]++;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!placed && !slot_live[i]) begin
						slot_live[i] = 1'b1;
						slot_addr[i] = mac;
						slot_rank[i] = '0;
						live_count++;
						placed = 1'b1;
					end
				end
			end
		end
		return live_count;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : driver
		int tx_wait;
		lru_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_ADD;
			address  <= '0;
			tx_wait  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				count_q.push_back(predict_count(kind, address));
				open_reqs--;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					kind     <= req.op;
					address  <= req.mac;
					tx_wait  = calm ? 0 : $urandom_range(0, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with per-result stall and one long hold-off
	always @(posedge clk or negedge arst_n) begin : monitor
		int rx_wait;
		int results_seen;
		int w;
		logic [CNT_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			results_seen = 0;
		end else if (out_valid && !out_stall) begin
			if (count_q.size() == 0) begin
				flag_error($sformatf("result with no request waiting, count %0d", count));
			end else begin
				want = count_q.pop_front();
				if (count !== want)
					flag_error($sformatf("count %0d, expected %0d", count, want));
			end
			results_seen++;
			if (results_seen == HOLD_AT)
				w = HOLD_LEN;
			else
				w = calm ? 0 : $urandom_range(0, 9);
			rx_wait = w;
			out_stall <= (w != 0);
		end else if (out_valid) begin
			// stall counts down only while a result is offered
			if (rx_wait <= 1) begin
				rx_wait = 0;
				out_stall <= 1'b0;
			end else begin
				rx_wait--;
			end
		end
	end

	// cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL lru_address_set_core");
		$finish;
	end

	// queue one request for the driver
	function automatic void queue_req(input logic op, input logic [ADDR_W-1:0] mac);
		pending_reqs.push_back('{op: op, mac: mac});
		open_reqs++;
	endfunction

	// wait until every request is accepted and every count returned
	task automatic drain();
		do
			@(posedge clk);
		while (open_reqs != 0 || count_q.size() != 0);
	endtask

	// capacity write while idle
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg = value;
	endtask

	// random requests over a pool of addresses so that refreshes are common
	task automatic queue_random(input int n, input int pool_n, input int remove_pct);
		logic [ADDR_W-1:0] pool [$];
		logic [ADDR_W-1:0] mac;
		logic op;
		for (int i = 0; i < pool_n; i++)
			pool.push_back(ADDR_W'({$urandom, $urandom}));
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 99) < remove_pct) ? KIND_REMOVE : KIND_ADD;
			if ($urandom_range(0, 9) == 0)
				mac = ADDR_W'({$urandom, $urandom});
			else
				mac = pool[$urandom_range(0, pool_n - 1)];
			queue_req(op, mac);
		end
	endtask

	// main sequence
	initial begin : main
		int ph_cap  [10] = '{64, 127, 0, 1, 2, 8, 64, 33, 63, 0};
		int ph_pool [10] = '{80, 90, 20, 4, 6, 16, 70, 50, 80, 40};
		int ph_rm   [10] = '{10, 15, 10, 20, 20, 15, 5, 20, 10, 20};
		bit ph_calm [10] = '{0, 0, 0, 1, 0, 0, 1, 0, 0, 0};
		for (int i = 0; i < ENTRIES; i++) begin
			slot_addr[i] = '0;
			slot_rank[i] = '0;
			slot_live[i] = 1'b0;
		end
		live_count = '0;
		cap_reg = CAP_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty remove, field extremes, refresh, ignored address
		@(negedge clk);
		queue_req(KIND_REMOVE, '0);
		queue_req(KIND_ADD, '0);
		queue_req(KIND_ADD, '1);
		queue_req(KIND_ADD, '0);
		queue_req(KIND_ADD, 48'h5555_5555_5555);
		queue_req(KIND_ADD, 48'hAAAA_AAAA_AAAA);
		queue_req(KIND_REMOVE, '1);
		drain();

		// capacity lowered below the count: refresh then new address
		write_capacity(CAP_W'(1));
		@(negedge clk);
		queue_req(KIND_ADD, 48'h5555_5555_5555);
		queue_req(KIND_ADD, 48'h1234_5678_9ABC);
		queue_req(KIND_ADD, 48'h1234_5678_9ABC);
		drain();

		// zero capacity: refresh of the only entry evicts it, empty add keeps nothing
		write_capacity(CAP_W'(0));
		@(negedge clk);
		queue_req(KIND_ADD, 48'h1234_5678_9ABC);
		queue_req(KIND_ADD, 48'hFEDC_BA98_7654);
		queue_req(KIND_REMOVE, '0);
		drain();

		// capacity above the slot count
		write_capacity(CAP_W'(127));
		@(negedge clk);
		queue_req(KIND_ADD, 48'h0000_0000_0001);
		queue_req(KIND_ADD, 48'h8000_0000_0000);
		queue_req(KIND_ADD, 48'h0000_0000_0001);
		queue_req(KIND_REMOVE, '0);
		queue_req(KIND_REMOVE, '0);
		queue_req(KIND_REMOVE, '0);
		drain();

		// random phases over several capacities
		for (int p = 0; p < 10; p++) begin
			if (p == 9) begin
				ph_cap[p]  = $urandom_range(0, 127);
				ph_pool[p] = $urandom_range(2, 90);
				ph_rm[p]   = $urandom_range(5, 40);
			end
			write_capacity(CAP_W'(ph_cap[p]));
			calm = ph_calm[p];
			queue_random(100, ph_pool[p], ph_rm[p]);
			drain();
		end

		// let any stray result show up
		repeat (150) @(posedge clk);
		if (count_q.size() != 0)
			flag_error($sformatf("%0d counts never returned", count_q.size()));
		if (errors == 0)
			$display("PASS lru_address_set_core");
		else
			$display("FAIL lru_address_set_core");
		$finish;
	end

endmodule

// ===== sim.f =====
design/las_pkg.sv
design/las_ram.sv
design/lru_address_set_core.sv
bench/tb_top.sv
